// ----- rtl/wpms_pkg.sv -----
// ----------------------------------------------------------------------------
// wpms_pkg - shared types and constants for the wildcard pattern matcher
// Opcodes, controller states, cell link records and default sizes.
// ----------------------------------------------------------------------------
package wpms_pkg;

	localparam int SYM_W           = 16;
	localparam int SCORE_W         = 30;
	localparam int SQ_W            = 2 * SYM_W;
	localparam int MAX_PATTERN_DEF = 64;
	localparam int MODULUS_DEF     = 998244353;
	localparam int SUM_W_DEF       = SQ_W + $clog2(MAX_PATTERN_DEF);

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_TEXT  = 2'd1,
		OP_FLUSH = 2'd2,
		OP_CLEAR = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETTLE,
		ST_REDUCE,
		ST_EMIT
	} state_t;

	// pattern symbol handed from cell to cell
	typedef struct packed {
		logic [SYM_W-1:0] value;
		logic             wild;
		logic             vld;
	} pat_t;

	// text symbol handed from cell to cell
	typedef struct packed {
		logic [SYM_W-1:0] value;
		logic             vld;
	} txt_t;

	// controls broadcast to every cell of the row
	typedef struct packed {
		logic pat_shift;
		logic pat_clear;
		logic txt_shift;
		logic txt_clear;
		logic txt_vld_in;
	} cell_ctrl_t;

endpackage

// ----- rtl/wpms_cell.sv -----
// ----------------------------------------------------------------------------
// wpms_cell - one position of the matcher row
// Holds one pattern symbol and one text symbol, squares their difference
// and adds it to the partial sum passed on to the next cell.
// ----------------------------------------------------------------------------
module wpms_cell #(
	parameter int SUM_W = wpms_pkg::SUM_W_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  wpms_pkg::cell_ctrl_t   ctrl,
	input  wpms_pkg::pat_t         pat_in,
	output wpms_pkg::pat_t         pat_out,
	input  wpms_pkg::txt_t         txt_in,
	output wpms_pkg::txt_t         txt_out,
	input  logic [SUM_W-1:0]       psum_in,
	output logic [SUM_W-1:0]       psum_out
);
	import wpms_pkg::*;

	logic [SYM_W-1:0] p_val_q;
	logic             p_wild_q;
	logic             p_vld_q;
	logic [SYM_W-1:0] t_val_q;
	logic             t_vld_q;
	logic [SYM_W-1:0] diff;
	logic             active;
	logic [SQ_W-1:0]  sq_q;
	logic [SUM_W-1:0] psum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_vld_q <= 1'b0;
			t_vld_q <= 1'b0;
		end else begin
			if (ctrl.pat_clear) begin
				p_vld_q <= 1'b0;
			end else if (ctrl.pat_shift) begin
				p_vld_q <= pat_in.vld;
			end
			if (ctrl.txt_clear) begin
				t_vld_q <= 1'b0;
			end else if (ctrl.txt_shift) begin
				t_vld_q <= txt_in.vld;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.pat_shift) begin
			p_val_q  <= pat_in.value;
			p_wild_q <= pat_in.wild;
		end
		if (ctrl.txt_shift) begin
			t_val_q <= txt_in.value;
		end
		sq_q   <= active ? (SQ_W'(diff) * SQ_W'(diff)) : '0;
		psum_q <= psum_in + SUM_W'(sq_q);
	end

	// absolute difference; wildcards and empty slots add nothing
	assign diff   = (t_val_q >= p_val_q) ? (t_val_q - p_val_q) : (p_val_q - t_val_q);
	assign active = p_vld_q & t_vld_q & ~p_wild_q;

	assign pat_out  = {p_val_q, p_wild_q, p_vld_q};
	assign txt_out  = {t_val_q, t_vld_q};
	assign psum_out = psum_q;

endmodule

// ----- rtl/wpms_mod.sv -----
// ----------------------------------------------------------------------------
// wpms_mod - modulo reduction by reciprocal multiplication
// Reduces the exact score sum modulo the constant modulus in three short
// stages: quotient estimate, multiply-subtract, one final correction.
// ----------------------------------------------------------------------------
module wpms_mod #(
	parameter int SUM_W   = wpms_pkg::SUM_W_DEF,
	parameter int MODULUS = wpms_pkg::MODULUS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [SUM_W-1:0]             sum,
	output logic                         busy,
	output logic [wpms_pkg::SCORE_W-1:0] score,
	output logic                         is_zero
);
	import wpms_pkg::*;

	localparam int RW = $clog2(MODULUS);
	localparam int EW = RW + SCORE_W;
	// floor(2^SUM_W / MODULUS): the quotient estimate is low by at most one,
	// so the first remainder stays below twice the modulus
	localparam logic [63:0]      RECIP     = (64'd1 << SUM_W) / 64'(MODULUS);
	localparam int               QW        = $clog2(RECIP + 1);
	localparam int               PW        = SUM_W + QW;
	localparam logic [QW-1:0]    RECIP_C   = QW'(RECIP);
	localparam logic [SUM_W-1:0] MOD_X     = SUM_W'(MODULUS);
	localparam logic [RW:0]      MOD_C     = (RW + 1)'(MODULUS);
	localparam logic [1:0]       STAGE_SUB = 2'd2;
	localparam logic [1:0]       STAGE_FIX = 2'd1;

	logic [1:0]       cnt_q;
	logic [SUM_W-1:0] x_s1;
	logic [QW-1:0]    q_s1;
	logic [RW:0]      r_s2;
	logic [RW-1:0]    rem_q;
	logic [PW-1:0]    prod;
	logic [SUM_W-1:0] qm;
	logic [SUM_W-1:0] x_rem;
	logic [RW:0]      r_sub;
	logic [RW-1:0]    rem_d;
	logic [EW-1:0]    rem_ext;

	assign prod  = PW'(sum) * PW'(RECIP_C);
	assign qm    = SUM_W'(q_s1) * MOD_X;
	assign x_rem = x_s1 - qm;
	assign r_sub = r_s2 - MOD_C;
	assign rem_d = (r_s2 >= MOD_C) ? r_sub[RW-1:0] : r_s2[RW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= STAGE_SUB;
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_s1 <= sum;
			q_s1 <= prod[PW-1:SUM_W];
		end
		if (cnt_q == STAGE_SUB) begin
			r_s2 <= x_rem[RW:0];
		end
		if (cnt_q == STAGE_FIX) begin
			rem_q <= rem_d;
		end
	end

	assign busy    = (cnt_q != '0);
	assign rem_ext = EW'(rem_q);
	assign score   = rem_ext[SCORE_W-1:0];
	assign is_zero = (rem_q == '0);

endmodule

// ----- rtl/wpms_ctrl.sv -----
// ----------------------------------------------------------------------------
// wpms_ctrl - request sequencer and result register
// Decodes requests, drives the cell row, paces each score through the row
// and the modulo unit, and holds the result until it is taken.
// ----------------------------------------------------------------------------
module wpms_ctrl #(
	parameter int MAX_PATTERN = wpms_pkg::MAX_PATTERN_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   opcode,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [wpms_pkg::SCORE_W-1:0] score,
	output logic                         is_match,
	output logic                         last_of_run,
	output wpms_pkg::cell_ctrl_t         cell_ctrl,
	output logic                         mod_start,
	input  logic                         mod_busy,
	input  logic [wpms_pkg::SCORE_W-1:0] mod_score,
	input  logic                         mod_zero
);
	import wpms_pkg::*;

	localparam int MW = $clog2(MAX_PATTERN + 1);
	localparam int SW = $clog2(MAX_PATTERN + 2);
	localparam logic [MW-1:0] M_FULL      = MW'(MAX_PATTERN);
	localparam logic [MW-1:0] M_ONE       = MW'(1);
	localparam logic [SW-1:0] SETTLE_DONE = SW'(MAX_PATTERN + 1);

	state_t             state_q;
	state_t             state_d;
	logic [MW-1:0]      m_q;
	logic [MW-1:0]      left_q;
	logic [SW-1:0]      settle_q;
	logic               seen_q;
	logic               flushing_q;
	logic               out_valid_q;
	logic [SCORE_W-1:0] score_q;
	logic               match_q;
	logic               last_q;
	logic               accept;
	logic               out_free;
	logic               out_load;
	logic               flush_go;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid & in_ready;
	assign out_free = ~out_valid_q | out_ready;
	assign flush_go = seen_q & (m_q > M_ONE);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (opcode)
						OP_TEXT:  if (m_q != '0) state_d = ST_SETTLE;
						OP_FLUSH: if (flush_go) state_d = ST_SETTLE;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_SETTLE: begin
				if (settle_q == SETTLE_DONE) state_d = ST_REDUCE;
			end
			ST_REDUCE: begin
				if (!mod_busy) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) state_d = (left_q > M_ONE) ? ST_SETTLE : ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cell_ctrl = '0;
		mod_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (opcode)
						OP_LOAD: cell_ctrl.pat_shift = (m_q < M_FULL);
						OP_TEXT: begin
							cell_ctrl.txt_shift  = 1'b1;
							cell_ctrl.txt_vld_in = 1'b1;
						end
						OP_FLUSH: begin
							// first partial overlap: push an empty slot
							cell_ctrl.txt_shift = flush_go;
							cell_ctrl.txt_clear = ~flush_go;
						end
						default: begin
							cell_ctrl.pat_clear = 1'b1;
							cell_ctrl.txt_clear = 1'b1;
						end
					endcase
				end
			end
			ST_SETTLE: mod_start = (settle_q == SETTLE_DONE);
			ST_REDUCE: mod_start = 1'b0;
			ST_EMIT: begin
				out_load            = out_free;
				cell_ctrl.txt_shift = out_free & (left_q > M_ONE);
				cell_ctrl.txt_clear = out_free & (left_q <= M_ONE) & flushing_q;
			end
			default: mod_start = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			m_q         <= '0;
			left_q      <= '0;
			settle_q    <= '0;
			seen_q      <= 1'b0;
			flushing_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cell_ctrl.pat_clear) begin
				m_q <= '0;
			end else if (cell_ctrl.pat_shift) begin
				m_q <= m_q + 1'b1;
			end

			if (cell_ctrl.txt_clear) begin
				seen_q <= 1'b0;
			end else if (accept && opcode == OP_TEXT) begin
				seen_q <= 1'b1;
			end

			if (accept && opcode == OP_TEXT) begin
				left_q     <= M_ONE;
				flushing_q <= 1'b0;
			end else if (accept && opcode == OP_FLUSH) begin
				left_q     <= m_q - 1'b1;
				flushing_q <= 1'b1;
			end else if (out_load) begin
				left_q <= left_q - 1'b1;
			end

			if (state_q != ST_SETTLE) begin
				settle_q <= '0;
			end else begin
				settle_q <= settle_q + 1'b1;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			score_q <= mod_score;
			match_q <= mod_zero;
			last_q  <= (left_q <= M_ONE);
		end
	end

	assign out_valid   = out_valid_q;
	assign score       = score_q;
	assign is_match    = match_q;
	assign last_of_run = last_q;

endmodule

// ----- rtl/wildcard_pattern_match_scores.sv -----
// Requests: load, clear and empty flush finish on acceptance. A text request with a loaded
//   pattern lets the row settle, reduces the sum in the modulo unit and then hands the
//   score off, waiting while the result port is stalled. One request at a time: in_ready
//   stays low until the last score is handed off; a flush repeats the settle, reduce and
//   hand-off steps for each partial-overlap score it gives.
// Reset: control, pattern length and all valid bits clear at once; no clearing pass.
// ----------------------------------------------------------------------------
// wildcard_pattern_match_scores - wildcard matcher with squared-difference scores
// A row of cells holds the pattern (newest symbol at cell 0) and the text
// window (newest symbol at cell 0); the partial sum ripples along the row.
// ----------------------------------------------------------------------------
module wildcard_pattern_match_scores #(
	parameter int MAX_PATTERN = wpms_pkg::MAX_PATTERN_DEF,
	parameter int MODULUS     = wpms_pkg::MODULUS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   opcode,
	input  logic [wpms_pkg::SYM_W-1:0]   symbol_value,
	input  logic                         is_wild,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [wpms_pkg::SCORE_W-1:0] score,
	output logic                         is_match,
	output logic                         last_of_run
);
	import wpms_pkg::*;

	// exact sum of up to MAX_PATTERN squares of 16-bit differences
	localparam int SUM_W = SQ_W + $clog2(MAX_PATTERN);

	cell_ctrl_t         cell_ctrl;
	logic               mod_start;
	logic               mod_busy;
	logic [SCORE_W-1:0] mod_score;
	logic               mod_zero;

	// index 0 is the row input; index k+1 is the output of cell k
	pat_t               pat_chain  [0:MAX_PATTERN];
	txt_t               txt_chain  [0:MAX_PATTERN];
	logic [SUM_W-1:0]   psum_chain [0:MAX_PATTERN];

	// Pattern symbols are kept in reverse: cell q holds pattern index m-1-q,
	// so cell q always meets the text symbol q steps old. A text request
	// then scores the full alignment directly. Each flush step shifts an
	// empty slot into the text window, sliding the text one more place
	// past the pattern, which gives the next partial-overlap score.
	assign pat_chain[0]  = {symbol_value, is_wild, 1'b1};
	assign txt_chain[0]  = {symbol_value, cell_ctrl.txt_vld_in};
	assign psum_chain[0] = '0;

	wpms_ctrl #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.score       (score),
		.is_match    (is_match),
		.last_of_run (last_of_run),
		.cell_ctrl   (cell_ctrl),
		.mod_start   (mod_start),
		.mod_busy    (mod_busy),
		.mod_score   (mod_score),
		.mod_zero    (mod_zero)
	);

	// Cell row: state is frozen while a score settles, so the partial sum
	// is final at the last cell by the time the modulo unit takes it.
	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
		wpms_cell #(
			.SUM_W (SUM_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (cell_ctrl),
			.pat_in   (pat_chain[k]),
			.pat_out  (pat_chain[k+1]),
			.txt_in   (txt_chain[k]),
			.txt_out  (txt_chain[k+1]),
			.psum_in  (psum_chain[k]),
			.psum_out (psum_chain[k+1])
		);
	end

	// reduce the exact sum once per score
	wpms_mod #(
		.SUM_W   (SUM_W),
		.MODULUS (MODULUS)
	) u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mod_start),
		.sum     (psum_chain[MAX_PATTERN]),
		.busy    (mod_busy),
		.score   (mod_score),
		.is_zero (mod_zero)
	);

endmodule

// ----- sim/wildcard_pattern_match_scores_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wildcard_pattern_match_scores_test - self-checking bench for the wildcard matcher
// Drives load, text, flush and clear requests through the valid/ready port,
// predicts every squared-difference score, and checks each result in order.
// ----------------------------------------------------------------------------
module wildcard_pattern_match_scores_test;
	import wpms_pkg::*;

	localparam int          MAX_PAT      = MAX_PATTERN_DEF;
	localparam int          RANDOM_ITEMS = 270;
	// idle time to watch for stray results after the last expected score
	localparam int          DRAIN_CYCLES = 2 * (MAX_PATTERN_DEF + 6);
	localparam int unsigned CYCLE_LIMIT  = 10_000_000;

	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic               is_match;
		logic               last_flag;
	} score_rec_t;

	// Predicts the scores of the pattern row and checks results against them.
	class wildcard_score_predictor;
		logic [SYM_W-1:0] pat_value[MAX_PAT];
		bit               pat_wild[MAX_PAT];
		int unsigned      pat_len;
		logic [SYM_W-1:0] text_hist[MAX_PAT];
		int unsigned      text_count;
		score_rec_t       pending_scores[$];
		int unsigned      error_count;

		function new();
			pat_len     = 0;
			text_count  = 0;
			error_count = 0;
		endfunction

		// sum of squared differences, modulo the modulus, where pattern position i meets the text
		// symbol (offset - i) steps older than the newest one
		function longint unsigned window_score(int unsigned offset);
			longint unsigned acc;
			longint          diff;
			int unsigned     age;
			acc = 0;
			for (int unsigned i = 0; i < pat_len && i <= offset; i++) begin
				age = offset - i;
				if (age < text_count && !pat_wild[i]) begin
					diff = longint'(int'(text_hist[age])) - longint'(int'(pat_value[i]));
					if (diff < 0)
						diff = -diff;
					acc += longint'(diff * diff);
				end
			end
			return acc % longint'(MODULUS_DEF);
		endfunction

		function void push_score(longint unsigned s, bit last_flag);
			score_rec_t rec;
			rec.score     = s[SCORE_W-1:0];
			rec.is_match  = (s == 0);
			rec.last_flag = last_flag;
			pending_scores.push_back(rec);
		endfunction

		function void note_request(opcode_t op, logic [SYM_W-1:0] v, logic w);
			int unsigned runs;
			case (op)
				OP_LOAD: begin
					if (pat_len < MAX_PAT) begin
						pat_value[pat_len] = v;
						pat_wild[pat_len]  = w;
						pat_len++;
					end
				end
				OP_TEXT: begin
					for (int k = MAX_PAT - 1; k > 0; k--)
						text_hist[k] = text_hist[k-1];
					text_hist[0] = v;
					if (text_count < MAX_PAT)
						text_count++;
					if (pat_len > 0)
						push_score(window_score(pat_len - 1), 1'b1);
				end
				OP_FLUSH: begin
					if (text_count > 0 && pat_len > 1) begin
						runs = pat_len - 1;
						for (int unsigned d = 0; d < runs; d++)
							push_score(window_score(runs - 1 - d), d + 1 == runs);
					end
					text_count = 0;
				end
				default: begin
					pat_len    = 0;
					text_count = 0;
				end
			endcase
		endfunction

		function void check_score(logic [SCORE_W-1:0] s, logic m, logic l);
			score_rec_t rec;
			if (pending_scores.size() == 0) begin
				$error("unexpected result: score %0d is_match %0b last_of_run %0b", s, m, l);
				error_count++;
				return;
			end
			rec = pending_scores.pop_front();
			if (s !== rec.score) begin
				$error("score: expected %0d, actual %0d", rec.score, s);
				error_count++;
			end
			if (m !== rec.is_match) begin
				$error("is_match: expected %0b, actual %0b", rec.is_match, m);
				error_count++;
			end
			if (l !== rec.last_flag) begin
				$error("last_of_run: expected %0b, actual %0b", rec.last_flag, l);
				error_count++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	opcode_t            opcode;
	logic [SYM_W-1:0]   symbol_value;
	logic               is_wild;
	logic               out_valid;
	logic               out_ready;
	logic [SCORE_W-1:0] score;
	logic               is_match;
	logic               last_of_run;

	wildcard_score_predictor scorer = new();

	int          send_idle_pct  = 0;
	int          recv_stall_pct = 0;
	int          requests_sent  = 0;
	int unsigned cycle_count    = 0;

	wildcard_pattern_match_scores dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.symbol_value (symbol_value),
		.is_wild      (is_wild),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.score        (score),
		.is_match     (is_match),
		.last_of_run  (last_of_run)
	);

	always #10 clk = ~clk;

	// Stall the result port at random; change ready only at the falling edge.
	always @(negedge clk) begin
		out_ready = ($urandom_range(99) >= recv_stall_pct);
	end

	// Check every result taken at a rising edge against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			scorer.check_score(score, is_match, last_of_run);
	end

	// Present one request at the falling edge, hold it until the block takes
	// it, then hand it to the predictor. Returns at the next falling edge
	// with valid still high, so back-to-back requests keep valid asserted.
	task automatic send_request(opcode_t op, logic [SYM_W-1:0] v, logic w);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid     = 1'b1;
		opcode       = op;
		symbol_value = v;
		is_wild      = w;
		do
			@(posedge clk);
		while (!in_ready);
		// a load into a full pattern is dropped and does not count
		if (!(op == OP_LOAD && scorer.pat_len >= MAX_PAT))
			requests_sent++;
		scorer.note_request(op, v, w);
		@(negedge clk);
	endtask

	// Favor values near both ends so that small differences, exact matches
	// and the widest differences all show up.
	function automatic logic [SYM_W-1:0] pick_symbol();
		case ($urandom_range(3))
			0:       return SYM_W'($urandom_range(0, 3));
			1:       return 16'hFFFF - SYM_W'($urandom_range(0, 3));
			default: return SYM_W'($urandom);
		endcase
	endfunction

	// Give up on a hung block.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("wildcard_pattern_match_scores_test: FAIL");
		$finish;
	end

	initial begin
		int               seq_count;
		int               plen;
		int               tlen;
		bit               copy_text;
		logic [SYM_W-1:0] v;

		clk          = 1'b0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		opcode       = OP_LOAD;
		symbol_value = '0;
		is_wild      = 1'b0;
		out_ready    = 1'b0;
		seq_count    = 0;

		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// ---- directed part ----
		// empty pattern: flush with no text, then text recorded with no score
		send_request(OP_FLUSH, 16'hFFFF, 1'b1);
		send_request(OP_TEXT,  16'h0000, 1'b1);
		send_request(OP_FLUSH, 16'h0000, 1'b0);
		// single-symbol pattern: widest difference, a match, and a flush that
		// gives nothing since there are no partial overlaps
		send_request(OP_LOAD,  16'hFFFF, 1'b0);
		send_request(OP_TEXT,  16'h0000, 1'b0);
		send_request(OP_TEXT,  16'hFFFF, 1'b0);
		send_request(OP_FLUSH, 16'h0000, 1'b0);
		// three-symbol pattern with a wildcard at the front
		send_request(OP_CLEAR, 16'hFFFF, 1'b1);
		send_request(OP_LOAD,  16'h0000, 1'b1);
		send_request(OP_LOAD,  16'h1234, 1'b0);
		send_request(OP_LOAD,  16'hFFFF, 1'b0);
		send_request(OP_TEXT,  16'hA5A5, 1'b0);
		send_request(OP_TEXT,  16'h1234, 1'b1);
		send_request(OP_TEXT,  16'hFFFF, 1'b0);
		send_request(OP_FLUSH, 16'h5A5A, 1'b1);
		// flush right after a flush: no text left, nothing comes out
		send_request(OP_FLUSH, 16'h0000, 1'b0);
		// grow the pattern while text is streaming
		send_request(OP_TEXT,  16'h0005, 1'b0);
		send_request(OP_LOAD,  16'h0007, 1'b0);
		send_request(OP_TEXT,  16'h0009, 1'b0);
		send_request(OP_FLUSH, 16'h0000, 1'b0);
		// clear, then text and flush against the empty pattern
		send_request(OP_CLEAR, 16'h0000, 1'b0);
		send_request(OP_TEXT,  16'h0001, 1'b0);
		send_request(OP_FLUSH, 16'hFFFF, 1'b1);

		// ---- random part ----
		// Mostly well-formed runs: clear, load a pattern, stream text (often
		// a copy of the pattern so matches happen), flush. Sprinkle noise.
		requests_sent = 0;
		while (requests_sent < RANDOM_ITEMS) begin
			// walk the idle phases: none, sender idle, receiver stall, both
			case (requests_sent * 4 / RANDOM_ITEMS)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 86;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 86;
				end
				default: begin
					send_idle_pct  = 24;
					recv_stall_pct = 24;
				end
			endcase

			if (seq_count > 0 && $urandom_range(9) == 0) begin
				send_request(opcode_t'($urandom_range(3)), pick_symbol(),
					1'($urandom_range(1)));
			end else begin
				if (seq_count == 0 || $urandom_range(4) != 0)
					send_request(OP_CLEAR, pick_symbol(), 1'($urandom_range(1)));
				// the first run fills the pattern and pushes past full
				if (seq_count == 0)
					plen = MAX_PAT + 2;
				else if ($urandom_range(7) == 0)
					plen = $urandom_range(0, 20);
				else
					plen = $urandom_range(1, 6);
				for (int k = 0; k < plen; k++)
					send_request(OP_LOAD, pick_symbol(), $urandom_range(3) == 0);

				tlen      = $urandom_range(0, 12);
				copy_text = 1'($urandom_range(1));
				for (int j = 0; j < tlen; j++) begin
					if ($urandom_range(19) == 0)
						send_request(OP_LOAD, pick_symbol(), 1'($urandom_range(1)));
					if (copy_text && scorer.pat_len > 0 && $urandom_range(7) != 0)
						v = scorer.pat_value[j % scorer.pat_len];
					else
						v = pick_symbol();
					send_request(OP_TEXT, v, 1'($urandom_range(1)));
				end
				if ($urandom_range(4) != 0)
					send_request(OP_FLUSH, pick_symbol(), 1'($urandom_range(1)));
				seq_count++;
			end
		end

		// drop valid, let every expected score arrive, then watch for strays
		in_valid = 1'b0;
		while (scorer.pending_scores.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (scorer.error_count == 0)
			$display("wildcard_pattern_match_scores_test: PASS");
		else
			$display("wildcard_pattern_match_scores_test: FAIL");
		$finish;
	end

endmodule
